[design/bkv_pkg.sv]
// Package for the bounded key-value map: request and status codes, the
// sequencer state type and the structs passed between the top level and its cells.
// No dependencies.
package bkv_pkg;

    localparam int BKV_CAPACITY = 64;
    localparam int DATA_W       = 32;

    localparam logic [DATA_W-1:0] NO_VALUE = '1;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_ERASE  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_DONE = 2'd0,
        STS_FULL = 2'd1,
        STS_MISS = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // broadcast command to every cell
    typedef struct packed {
        logic match_en;
        logic insert;
        logic erase;
    } t_cell_ctl;

    // running hit/value passed from cell to cell
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } t_chain;

endpackage

[design/bkv_ifs.sv]
// Request and response channel interfaces for the key-value map.
// Depends on bkv_pkg.
interface bkv_req_if;
    import bkv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    modport source (output valid, req_type, key, value, input ready);
    modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface bkv_rsp_if;
    import bkv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] found_value;
    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface

[design/bkv_cell.sv]
// One storage cell of the map: key, value, valid flag and duplicate rank,
// with its own key compare and a link in the hit/value chain. Depends on bkv_pkg.
module bkv_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bkv_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_sel,
    input  logic [bkv_pkg::DATA_W-1:0] i_key,
    input  logic [bkv_pkg::DATA_W-1:0] i_value,
    input  bkv_pkg::t_chain          i_chain,
    input  logic [IW-1:0]            i_idx,
    output bkv_pkg::t_chain          o_chain,
    output logic [IW-1:0]            o_idx,
    output logic                     o_top
);
    import bkv_pkg::*;

    logic              r_valid;
    logic [IW-1:0]     r_rank;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_value;
    logic              r_hit;
    logic              r_top;

    // control state: valid, rank and match flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_hit   <= 1'b0;
            r_top   <= 1'b0;
        end else begin
            if (i_ctl.match_en) begin
                r_hit <= r_valid && (r_key == i_key);
                r_top <= r_valid && (r_key == i_key) && (r_rank == '0);
            end
            if (i_ctl.insert) begin
                if (i_sel) begin
                    r_valid <= 1'b1;
                    r_rank  <= '0;
                end else if (r_hit) begin
                    r_rank <= r_rank + 1'b1;
                end
            end else if (i_ctl.erase) begin
                if (r_top) begin
                    r_valid <= 1'b0;
                end else if (r_hit && (r_rank != '0)) begin
                    r_rank <= r_rank - 1'b1;
                end
            end
        end
    end

    // payload, written on insert into this slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && i_sel) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // fold this cell's newest-match into the chain
    assign o_chain.hit   = i_chain.hit | r_top;
    assign o_chain.value = i_chain.value | (r_top ? r_value : '0);
    assign o_idx         = i_idx | (r_top ? IW'(IDX) : '0);
    assign o_top         = r_top;

endmodule

[design/bkv_free_stack.sv]
// Stack of free slot numbers with its fill count. Entries below the low-water
// mark have never been popped and read as their own index. Depends on bkv_pkg.
module bkv_free_stack #(
    parameter int CAPACITY = bkv_pkg::BKV_CAPACITY,
    parameter int IW       = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic          i_pop,
    input  logic          i_push,
    input  logic [IW-1:0] i_push_slot,
    output logic [IW-1:0] o_top_slot,
    output logic          o_empty
);
    import bkv_pkg::*;

    logic [IW-1:0]    r_mem [CAPACITY];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_low;
    logic [IW-1:0]    r_rd_data;
    logic [IW-1:0]    r_rd_idx;
    logic             r_rd_fresh;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_low;
    logic [CNT_W-1:0] top_pos;
    logic [IW-1:0]    rd_idx;
    logic             full;

    assign o_empty = (r_count == '0);
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign top_pos = o_empty ? '0 : r_count - 1'b1;
    assign rd_idx  = top_pos[IW-1:0];

    // count and low-water mark
    always_comb begin
        n_count = r_count;
        n_low   = r_low;
        if (i_pop && !o_empty) begin
            n_count = r_count - 1'b1;
            if (top_pos < r_low) begin
                n_low = top_pos;
            end
        end else if (i_push && !full) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(CAPACITY);
            r_low   <= CNT_W'(CAPACITY);
        end else begin
            r_count <= n_count;
            r_low   <= n_low;
        end
    end

    // slot memory: registered read of the top, write on push
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[rd_idx];
            r_rd_idx   <= rd_idx;
            r_rd_fresh <= (top_pos < r_low);
        end
        if (i_push && !full) begin
            r_mem[r_count[IW-1:0]] <= i_push_slot;
        end
    end

    assign o_top_slot = r_rd_fresh ? r_rd_idx : r_rd_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("free count above capacity");
    a_low_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_count)
        else $error("low-water mark above fill count");
    a_no_pop_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && i_push))
        else $error("pop and push in one cycle");

endmodule

[design/bounded_key_value_map.sv]
// Top level of the bounded key-value map: request sequencer, row of cells,
// free-slot stack and response register. Depends on bkv_pkg, bkv_ifs, bkv_cell,
// bkv_free_stack.
//
//  channel  | dir | payload                         | beat taken when
//  ---------+-----+---------------------------------+--------------------
//  i_req    | in  | req_type[1:0] key[31:0] value   | valid && ready
//  o_rsp    | out | status[1:0] found_value[31:0]   | valid && ready
//
// A request goes through accept, key compare in every cell, cell/stack update and
// load of the response register, in that order; the sequencer holds one request.
// i_req.ready is high only in the idle state; the next request is taken while
// an earlier response still waits in the output register.
// A held response stalls only the load step of the following request.
// Synchronous reset empties the map at once; the free stack needs no clearing pass.
module bounded_key_value_map #(
    parameter int CAPACITY = bkv_pkg::BKV_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bkv_req_if.sink   i_req,
    bkv_rsp_if.source o_rsp
);
    import bkv_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    t_state            r_state;
    t_state            n_state;
    t_req              r_req;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_value;
    t_status           r_res_status;
    logic [DATA_W-1:0] r_res_value;
    t_status           n_res_status;
    logic [DATA_W-1:0] n_res_value;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_value;

    t_cell_ctl         cell_ctl;
    logic              stk_rd_en;
    logic              stk_pop;
    logic              stk_push;
    logic              stk_empty;
    logic [IW-1:0]     stk_top;
    logic              out_load;
    logic              req_take;
    logic              out_free;

    t_chain            w_chain [CAPACITY+1];
    logic [IW-1:0]     w_idx   [CAPACITY+1];
    logic [CAPACITY-1:0] w_top;
    logic [CAPACITY-1:0] w_sel;

    assign out_free = !r_out_valid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_req.valid) n_state = ST_MATCH;
            ST_MATCH:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_OUT;
            ST_OUT:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        req_take          = 1'b0;
        cell_ctl.match_en = 1'b0;
        cell_ctl.insert   = 1'b0;
        cell_ctl.erase    = 1'b0;
        stk_rd_en         = 1'b0;
        stk_pop           = 1'b0;
        stk_push          = 1'b0;
        out_load          = 1'b0;
        n_res_status      = r_res_status;
        n_res_value       = r_res_value;
        case (r_state)
            ST_IDLE: req_take = 1'b1;
            ST_MATCH: begin
                cell_ctl.match_en = 1'b1;
                stk_rd_en         = 1'b1;
            end
            ST_UPDATE: begin
                n_res_status = STS_DONE;
                n_res_value  = NO_VALUE;
                case (r_req)
                    REQ_INSERT: begin
                        if (stk_empty) begin
                            n_res_status = STS_FULL;
                        end else begin
                            cell_ctl.insert = 1'b1;
                            stk_pop         = 1'b1;
                        end
                    end
                    REQ_FIND: begin
                        if (w_chain[CAPACITY].hit) begin
                            n_res_value = w_chain[CAPACITY].value;
                        end else begin
                            n_res_status = STS_MISS;
                        end
                    end
                    REQ_ERASE: begin
                        if (w_chain[CAPACITY].hit) begin
                            cell_ctl.erase = 1'b1;
                            stk_push       = 1'b1;
                        end else begin
                            n_res_status = STS_MISS;
                        end
                    end
                    default: ;
                endcase
            end
            ST_OUT: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and response payload
    always_ff @(posedge i_clk) begin
        if (req_take && i_req.valid) begin
            r_req   <= t_req'(i_req.req_type);
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    assign i_req.ready       = req_take;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_value;

    // row of cells
    assign w_chain[0].hit   = 1'b0;
    assign w_chain[0].value = '0;
    assign w_idx[0]         = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_sel[g] = (stk_top == IW'(g));
        bkv_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_sel   (w_sel[g]),
            .i_key   (r_key),
            .i_value (r_value),
            .i_chain (w_chain[g]),
            .i_idx   (w_idx[g]),
            .o_chain (w_chain[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_top   (w_top[g])
        );
    end

    bkv_free_stack #(
        .CAPACITY (CAPACITY)
    ) u_free_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (stk_rd_en),
        .i_pop       (stk_pop),
        .i_push      (stk_push),
        .i_push_slot (w_idx[CAPACITY]),
        .o_top_slot  (stk_top),
        .o_empty     (stk_empty)
    );

    a_one_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_top))
        else $error("more than one newest entry for a key");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> !i_req.ready)
        else $error("request taken while one is in flight");

endmodule

[bench/bkv_map_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the bounded key-value map: follows both channels, keeps its own
// copy of the map and checks every response beat. Depends on bkv_pkg and bkv_ifs.
module bkv_map_checker #(
    parameter int CAPACITY = bkv_pkg::BKV_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bkv_req_if   i_req,
    bkv_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_refusals,
    output int   o_find_hits
);
    import bkv_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] value;
    } t_map_answer;

    // shadow copy of the map
    logic [DATA_W-1:0] slot_key   [CAPACITY];
    logic [DATA_W-1:0] slot_value [CAPACITY];
    bit                slot_live  [CAPACITY];
    int unsigned       slot_rank  [CAPACITY];
    int unsigned       free_stack [CAPACITY];
    int unsigned       free_top;

    t_map_answer answers_due[$];
    int fails;
    int checked;
    int full_refusals;
    int find_hits;

    function automatic void clear_map();
        for (int i = 0; i < CAPACITY; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_live[i]  = 1'b0;
            slot_rank[i]  = 0;
            free_stack[i] = i;
        end
        free_top = CAPACITY;
    endfunction

    // slot of the newest live entry with this key, CAPACITY when absent
    function automatic int unsigned newest_of(logic [DATA_W-1:0] k);
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_live[i] && slot_key[i] == k && slot_rank[i] == 0) return i;
        end
        return CAPACITY;
    endfunction

    // applies one request to the shadow map and returns the answer it earns
    function automatic t_map_answer apply_request(logic [1:0] kind, logic [DATA_W-1:0] k,
                                                  logic [DATA_W-1:0] v);
        t_map_answer ans;
        int unsigned s;
        ans.status = STS_DONE;
        ans.value  = NO_VALUE;
        case (kind)
            REQ_INSERT: begin
                if (free_top == 0) begin
                    ans.status = STS_FULL;
                    full_refusals++;
                end else begin
                    s = free_stack[free_top-1];
                    free_top--;
                    // older copies of the key move one place down
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_live[i] && slot_key[i] == k) slot_rank[i]++;
                    end
                    slot_key[s]   = k;
                    slot_value[s] = v;
                    slot_live[s]  = 1'b1;
                    slot_rank[s]  = 0;
                end
            end
            REQ_FIND: begin
                s = newest_of(k);
                if (s < CAPACITY) begin
                    ans.value = slot_value[s];
                    find_hits++;
                end else begin
                    ans.status = STS_MISS;
                end
            end
            REQ_ERASE: begin
                s = newest_of(k);
                if (s < CAPACITY) begin
                    slot_live[s] = 1'b0;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_live[i] && slot_key[i] == k && slot_rank[i] != 0)
                            slot_rank[i]--;
                    end
                    if (free_top < CAPACITY) begin
                        free_stack[free_top] = s;
                        free_top++;
                    end
                end else begin
                    ans.status = STS_MISS;
                end
            end
            default: ;  // unused code: no change, plain done
        endcase
        return ans;
    endfunction

    function automatic void note_failure(string what, t_map_answer want);
        fails++;
        if (fails <= 10)
            $display("%0t %s: status %0d value %h, expected status %0d value %h",
                     $realtime, what, i_rsp.status, i_rsp.found_value,
                     want.status, want.value);
    endfunction

    initial clear_map();

    // response side first: a beat accepted on this edge cannot be answered on it
    always @(posedge i_clk) begin
        t_map_answer want;
        if (!i_rst_n) begin
            clear_map();
            answers_due.delete();
            fails         = 0;
            checked       = 0;
            full_refusals = 0;
            find_hits     = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                checked++;
                if (answers_due.size() == 0) begin
                    want.status = STS_DONE;
                    want.value  = NO_VALUE;
                    note_failure("response with nothing outstanding", want);
                end else begin
                    want = answers_due.pop_front();
                    if (i_rsp.status !== want.status || i_rsp.found_value !== want.value)
                        note_failure("response mismatch", want);
                end
            end
            if (i_req.valid && i_req.ready)
                answers_due.push_back(apply_request(i_req.req_type, i_req.key, i_req.value));
        end
        o_fail_count    <= fails;
        o_pending       <= answers_due.size();
        o_checked       <= checked;
        o_full_refusals <= full_refusals;
        o_find_hits     <= find_hits;
    end

endmodule

[bench/bounded_key_value_map_tb.sv]
`timescale 1ns / 1ps
// Top of the key-value map bench: clock, reset, request and response drivers,
// watchdog and verdict. Depends on bkv_pkg, bkv_ifs, bkv_map_checker and the RTL.
module bounded_key_value_map_tb;
    import bkv_pkg::*;

    localparam logic [DATA_W-1:0] KEY_MIN   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] KEY_MAX   = 32'h7FFF_FFFF;
    localparam int                LONG_HOLD = 300;
    localparam int                WDOG_MAX  = 3000;

    logic i_clk;
    logic i_rst_n;

    bkv_req_if req_ch ();
    bkv_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;
    int full_refusals;
    int find_hits;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int items_sent    = 0;
    int idle_cycles   = 0;

    logic [DATA_W-1:0] key_pool [16];
    int idle_send_tab [4] = '{0, 54, 0, 34};
    int stall_tab     [4] = '{0, 0, 54, 34};

    bounded_key_value_map i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bkv_map_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_ch),
        .i_rsp           (rsp_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_refusals (full_refusals),
        .o_find_hits     (find_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // response ready: random stalls, plus a long hold-off when one is requested
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                         WDOG_MAX, pending);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // offers one request beat and returns on the edge that takes it
    task automatic send_beat(input t_req kind, input logic [DATA_W-1:0] k,
                             input logic [DATA_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.key      <= k;
        req_ch.value    <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // drops valid and waits for every outstanding response
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_key(int fresh_pct);
        if ($urandom_range(0, 99) < fresh_pct) return $urandom;
        return key_pool[$urandom_range(0, 15)];
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 39))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            3:       return NO_VALUE;
            default: return $urandom;
        endcase
    endfunction

    // random requests with a given mix; what is left of 100 goes to the unused code
    task automatic run_block(input int n, input int ins_pct, input int find_pct,
                             input int erase_pct);
        int   roll;
        t_req kind;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                kind = REQ_INSERT;
            else if (roll < ins_pct + find_pct)
                kind = REQ_FIND;
            else if (roll < ins_pct + find_pct + erase_pct)
                kind = REQ_ERASE;
            else
                kind = REQ_NONE;
            send_beat(kind, pick_key(kind == REQ_ERASE ? 5 : 12), pick_value());
        end
    endtask

    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_NONE;
        req_ch.key      <= '0;
        req_ch.value    <= '0;
        i_rst_n         <= 1'b0;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = NO_VALUE;
        for (int i = 4; i < 16; i++) key_pool[i] = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: misses on an empty map, extremes, duplicates newest first,
        // the unused code, and a freed slot taken again
        send_beat(REQ_FIND,   KEY_MIN, '0);
        send_beat(REQ_ERASE,  KEY_MAX, '0);
        send_beat(REQ_INSERT, KEY_MIN, KEY_MAX);
        send_beat(REQ_INSERT, KEY_MAX, KEY_MIN);
        send_beat(REQ_INSERT, '0, '0);
        send_beat(REQ_INSERT, NO_VALUE, NO_VALUE);
        send_beat(REQ_INSERT, KEY_MIN, 32'd5);
        send_beat(REQ_INSERT, KEY_MIN, 32'd6);
        send_beat(REQ_FIND,   KEY_MIN, '0);
        send_beat(REQ_ERASE,  KEY_MIN, '0);
        send_beat(REQ_FIND,   KEY_MIN, '0);
        send_beat(REQ_ERASE,  KEY_MIN, '0);
        send_beat(REQ_FIND,   KEY_MIN, '0);
        send_beat(REQ_FIND,   KEY_MAX, NO_VALUE);
        send_beat(REQ_FIND,   '0, '0);
        send_beat(REQ_FIND,   NO_VALUE, '0);
        send_beat(REQ_NONE,   NO_VALUE, NO_VALUE);
        send_beat(REQ_ERASE,  NO_VALUE, '0);
        send_beat(REQ_FIND,   NO_VALUE, '0);
        send_beat(REQ_ERASE,  KEY_MIN, '0);
        send_beat(REQ_ERASE,  KEY_MIN, '0);
        send_beat(REQ_INSERT, KEY_MIN, 32'hA5A5_A5A5);
        send_beat(REQ_FIND,   KEY_MIN, '0);
        wait_drained();

        // random: fill to the brim, mixed traffic, drain, mixed, per idling phase
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_send_tab[p];
            stall_pct     = stall_tab[p];
            run_block(90, 82, 10, 5);
            run_block(90, 40, 35, 20);
            run_block(90, 10, 20, 67);
            run_block(80, 40, 35, 20);
            wait_drained();
            if (p == 0) begin
                // long response hold-off while requests keep coming
                hold_requests++;
                run_block(30, 50, 30, 17);
                wait_drained();
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("ran %0d requests, checked %0d responses", items_sent, checked);
        $display("inserts refused on a full map: %0d, find hits: %0d",
                 full_refusals, find_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failing responses, %0d outstanding", fail_count, pending);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
